// ===== rtl/sbc_pkg.sv =====
package sbc_pkg;

  // Width of every payload field and of the configuration data bus
  localparam int unsigned DataW = 64;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegKeyLast = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDecrypt = 3'd4;

  // z sequences: element j sits at bit SeqLen-1-j, so each literal reads element 0 first
  localparam int unsigned SeqLen   = 62;
  localparam int unsigned SeqCount = 5;
  localparam int unsigned ZIdxW    = 6;

  typedef logic [SeqLen-1:0] zseq_t;

  localparam zseq_t ZSeq [SeqCount] = '{
    62'b11111010001001010110000111001101111101000100101011000011100110,
    62'b10001110111110010011000010110101000111011111001001100001011010,
    62'b10101111011100000011010010011000101000010001111110010110110011,
    62'b11011011101011000110010111100000010010001010011100110100001111,
    62'b11010001111001101011011000100000010111000011001010010011101111
  };

endpackage

// ===== rtl/sbc_if.sv =====
interface sbc_in_if;
  import sbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] block_upper;
  logic [DataW-1:0] block_lower;

  modport source (output valid, output block_upper, output block_lower, input ready);
  modport sink   (input valid, input block_upper, input block_lower, output ready);
endinterface

interface sbc_out_if;
  import sbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] result_upper;
  logic [DataW-1:0] result_lower;

  modport source (output valid, output result_upper, output result_lower, input ready);
  modport sink   (input valid, input result_upper, input result_lower, output ready);
endinterface

// ===== rtl/simon_block_cipher_ecb.sv =====
// Simon block cipher, ECB mode: each 128-bit block is encrypted or decrypted on its own.
// Channels: in_i carries a block (block_upper is the left Feistel word), out_o returns
// the transformed block. Both use valid/ready; an item moves when both are high.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0..3 key words,
// 4 decrypt mode). Write it only while no block is in flight.
// Timing: one Feistel round per cycle on a single round unit, fed from a round key
// RAM with a registered read port. A block is accepted in IDLE, then primes the key
// read in PRIME and runs its rounds in RUN; in_i is ready only in IDLE, so the next
// block is not accepted until the current one has finished its rounds.
// The first block after reset or after any key word write first runs the key schedule,
// one round key per cycle written to the RAM in EXPAND, before PRIME.
// Reset clears the key words, decrypt mode, the schedule-valid flag and the output.
// The result sits in an output register, so a stalled receiver does not stop the next
// block from being accepted; if the next result finishes while the previous one is
// still held, the core waits until out_o drains, then returns to IDLE.
module simon_block_cipher_ecb #(
  parameter int unsigned WORD_BITS      = 64,
  parameter int unsigned KEY_WORDS      = 4,
  parameter int unsigned ROUNDS         = 72,
  parameter int unsigned SEQUENCE_INDEX = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sbc_pkg::DataW-1:0]    cfg_data_i,
  sbc_in_if.sink                       in_i,
  sbc_out_if.source                    out_o
);
  import sbc_pkg::*;

  localparam int unsigned AddrW  = $clog2(ROUNDS);
  localparam int unsigned KIdxW  = $clog2(KEY_WORDS);
  localparam int unsigned SeqSel = SEQUENCE_INDEX % SeqCount;
  localparam zseq_t       ZRow   = ZSeq[SeqSel];

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_PRIME,
    S_RUN,
    S_FLUSH
  } state_e;

  function automatic word_t rot_left(word_t x, int unsigned r);
    return (x << r) | (x >> (WORD_BITS - r));
  endfunction

  function automatic word_t round_f(word_t x);
    return (rot_left(x, 1) & rot_left(x, 8)) ^ rot_left(x, 2);
  endfunction

  state_e            state_q;
  logic [AddrW-1:0]  cnt_q;
  logic [ZIdxW-1:0]  zidx_q;
  logic [AddrW-1:0]  rd_addr_q;
  word_t             rk_q;
  word_t             x_q, y_q;
  word_t             w_q   [KEY_WORDS];
  word_t             key_q [KEY_WORDS];
  logic              dec_q;
  logic              keys_ready_q;
  logic              out_valid_q;
  logic [DataW-1:0]  res_upper_q, res_lower_q;

  word_t             mem [ROUNDS];

  logic              in_acc;
  logic              out_free;
  logic              res_load;
  logic              load_phase;
  logic              mem_we;
  word_t             mem_wd;
  word_t             ks_t0, ks_t1, key_new;
  logic              z_cur;
  logic              rd_last;
  logic [AddrW-1:0]  rd_start, rd_next;
  word_t             op_a, op_b, rnd_new, x_new, y_new;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // A finished block enters the output register this cycle
  assign res_load = out_free
                    && ((state_q == S_RUN && cnt_q == AddrW'(ROUNDS - 1))
                        || state_q == S_FLUSH);

  // Key schedule step over the window of the last KEY_WORDS round keys
  assign load_phase = cnt_q < AddrW'(KEY_WORDS);
  assign z_cur      = ZRow[ZIdxW'(SeqLen - 1) - zidx_q];
  assign ks_t0      = rot_left(w_q[KEY_WORDS-1], WORD_BITS - 3)
                      ^ ((KEY_WORDS == 4) ? w_q[1] : '0);
  assign ks_t1      = ks_t0 ^ rot_left(ks_t0, WORD_BITS - 1);
  assign key_new    = ~w_q[0] ^ ks_t1 ^ word_t'(z_cur) ^ word_t'(3);

  assign mem_we = (state_q == S_EXPAND);
  assign mem_wd = load_phase ? w_q[cnt_q[KIdxW-1:0]] : key_new;

  // Round key read address walks up for encryption and down for decryption
  assign rd_start = dec_q ? AddrW'(ROUNDS - 1) : '0;
  assign rd_last  = dec_q ? (rd_addr_q == '0) : (rd_addr_q == AddrW'(ROUNDS - 1));
  assign rd_next  = dec_q ? (rd_addr_q - AddrW'(1)) : (rd_addr_q + AddrW'(1));

  // Shared Feistel round: the roles of the two words swap with direction
  assign op_a    = dec_q ? y_q : x_q;
  assign op_b    = dec_q ? x_q : y_q;
  assign rnd_new = op_b ^ round_f(op_a) ^ rk_q;
  assign x_new   = dec_q ? op_a : rnd_new;
  assign y_new   = dec_q ? rnd_new : op_a;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q] <= mem_wd;
    end
    rk_q <= mem[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      zidx_q       <= '0;
      rd_addr_q    <= '0;
      dec_q        <= 1'b0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      res_upper_q  <= '0;
      res_lower_q  <= '0;
      for (int j = 0; j < KEY_WORDS; j++) begin
        key_q[j] <= '0;
        w_q[j]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        for (int j = 0; j < KEY_WORDS; j++) begin
          if (cfg_idx_i == CfgIdxW'(j)) begin
            key_q[j] <= cfg_data_i[WORD_BITS-1:0];
          end
        end
        if (cfg_idx_i <= RegKeyLast) begin
          keys_ready_q <= 1'b0;
        end
        if (cfg_idx_i == RegDecrypt) begin
          dec_q <= cfg_data_i[0];
        end
      end

      if (out_o.ready && !res_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            x_q       <= in_i.block_upper[WORD_BITS-1:0];
            y_q       <= in_i.block_lower[WORD_BITS-1:0];
            rd_addr_q <= rd_start;
            cnt_q     <= '0;
            if (!keys_ready_q) begin
              w_q     <= key_q;
              zidx_q  <= '0;
              state_q <= S_EXPAND;
            end else begin
              state_q <= S_PRIME;
            end
          end
        end
        S_EXPAND: begin
          if (!load_phase) begin
            for (int j = 0; j < KEY_WORDS - 1; j++) begin
              w_q[j] <= w_q[j+1];
            end
            w_q[KEY_WORDS-1] <= key_new;
            zidx_q <= (zidx_q == ZIdxW'(SeqLen - 1)) ? '0 : zidx_q + ZIdxW'(1);
          end
          if (cnt_q == AddrW'(ROUNDS - 1)) begin
            keys_ready_q <= 1'b1;
            cnt_q        <= '0;
            state_q      <= S_PRIME;
          end else begin
            cnt_q <= cnt_q + AddrW'(1);
          end
        end
        S_PRIME: begin
          if (!rd_last) begin
            rd_addr_q <= rd_next;
          end
          state_q <= S_RUN;
        end
        S_RUN: begin
          x_q <= x_new;
          y_q <= y_new;
          if (!rd_last) begin
            rd_addr_q <= rd_next;
          end
          if (cnt_q == AddrW'(ROUNDS - 1)) begin
            cnt_q <= '0;
            if (out_free) begin
              res_upper_q <= DataW'(x_new);
              res_lower_q <= DataW'(y_new);
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_FLUSH;
            end
          end else begin
            cnt_q <= cnt_q + AddrW'(1);
          end
        end
        S_FLUSH: begin
          // hold the finished block until the output register drains
          if (out_free) begin
            res_upper_q <= DataW'(x_q);
            res_lower_q <= DataW'(y_q);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_upper = res_upper_q;
  assign out_o.result_lower = res_lower_q;

`ifndef ASSERT_OFF
  a_stale_keys_expand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !keys_ready_q) |=> (state_q == S_EXPAND))
    else $error("block accepted with stale keys did not start key expansion");

  a_expand_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXPAND && cnt_q == AddrW'(ROUNDS - 1) && !cfg_we_i)
      |=> (keys_ready_q && state_q == S_PRIME))
    else $error("key expansion end did not mark keys ready");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RUN || $past(state_q) == S_FLUSH))
    else $error("result appeared without a finished block");

  a_rd_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_addr_q <= AddrW'(ROUNDS - 1))
    else $error("round key read address out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(res_upper_q) && $stable(res_lower_q))
    else $error("held result was overwritten");
`endif

endmodule

// ===== tb/tb_simon_block_cipher_ecb.sv =====
`timescale 1ns / 100ps

module tb_simon_block_cipher_ecb;
  import sbc_pkg::*;

  localparam int unsigned Rounds     = 72;
  localparam int unsigned KeyWords   = 4;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned IdlePct    = 31;

  localparam logic [CfgIdxW-1:0] RegKeyFirst    = '0;
  localparam logic [CfgIdxW-1:0] RegUnusedFirst = RegDecrypt + 1'b1;

  // z sequence 4, element j at bit 61-j
  localparam logic [61:0] ZBits =
    62'b11010001111001101011011000100000010111000011001010010011101111;

  typedef struct packed {
    logic [DataW-1:0] upper;
    logic [DataW-1:0] lower;
  } block_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_data_i;

  sbc_in_if  in_if ();
  sbc_out_if out_if ();

  simon_block_cipher_ecb uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // Cipher state as seen by the predictor
  logic [DataW-1:0] key_words [KeyWords];
  logic             decrypt_sel;
  logic [DataW-1:0] round_keys [Rounds];
  logic             round_keys_valid;

  block_t      pending_blocks [$];
  block_t      want;
  int unsigned mismatches;
  int unsigned cycles;
  bit          burst_mode;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= burst_mode || ($urandom_range(99) >= IdlePct);
  end

  function automatic logic [DataW-1:0] rotl(input logic [DataW-1:0] x, input int r);
    return (x << r) | (x >> (DataW - r));
  endfunction

  function automatic logic [DataW-1:0] rotr(input logic [DataW-1:0] x, input int r);
    return (x >> r) | (x << (DataW - r));
  endfunction

  function automatic logic [DataW-1:0] feistel_mix(input logic [DataW-1:0] x);
    return (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
  endfunction

  function automatic void expand_round_keys();
    logic [DataW-1:0] t;
    for (int i = 0; i < KeyWords; i++) round_keys[i] = key_words[i];
    for (int i = KeyWords; i < Rounds; i++) begin
      t = rotr(round_keys[i-1], 3) ^ round_keys[i-3];
      t = t ^ rotr(t, 1);
      round_keys[i] = ~round_keys[i-KeyWords] ^ t ^ 64'd3 ^
                      {63'd0, ZBits[61 - ((i - KeyWords) % 62)]};
    end
    round_keys_valid = 1'b1;
  endfunction

  function automatic block_t transform_block(input logic [DataW-1:0] left,
                                             input logic [DataW-1:0] right);
    logic [DataW-1:0] x, y, t;
    block_t r;
    x = left;
    y = right;
    if (!round_keys_valid) expand_round_keys();
    if (!decrypt_sel) begin
      for (int i = 0; i < Rounds; i++) begin
        t = x;
        x = y ^ feistel_mix(x) ^ round_keys[i];
        y = t;
      end
    end else begin
      for (int i = Rounds - 1; i >= 0; i--) begin
        t = y;
        y = x ^ feistel_mix(y) ^ round_keys[i];
        x = t;
      end
    end
    r.upper = x;
    r.lower = y;
    return r;
  endfunction

  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(DataW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays high for a following item
  task automatic send_block(input logic [DataW-1:0] left, input logic [DataW-1:0] right,
                            output block_t predicted);
    while (!burst_mode && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.block_upper <= left;
    in_if.block_lower <= right;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = transform_block(left, right);
    pending_blocks = {pending_blocks, predicted};
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    if (idx <= RegKeyLast) begin
      key_words[idx]   = data;
      round_keys_valid = 1'b0;
    end else if (idx == RegDecrypt) begin
      decrypt_sel = data[0];
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (Rounds + 4) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [DataW-1:0] k0, input logic [DataW-1:0] k1,
                          input logic [DataW-1:0] k2, input logic [DataW-1:0] k3);
    write_reg(RegKeyFirst, k0);
    write_reg(RegKeyFirst + 3'd1, k1);
    write_reg(RegKeyFirst + 3'd2, k2);
    write_reg(RegKeyFirst + 3'd3, k3);
  endtask

  // Zero key and encrypt mode straight out of reset
  task automatic test_reset_state();
    block_t res;
    send_block('0, '0, res);
    send_block('1, '1, res);
    wait_quiet();
  endtask

  task automatic test_known_vector();
    block_t res;
    load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    write_reg(RegDecrypt, 64'd0);
    send_block(64'h74206e69206d6f6f, 64'h6d69732061207369, res);
    wait_quiet();
    write_reg(RegDecrypt, 64'd1);
    send_block(res.upper, res.lower, res);
    wait_quiet();
  endtask

  task automatic test_field_extremes();
    block_t res;
    load_key('1, '1, '1, '1);
    write_reg(RegDecrypt, 64'd0);
    send_block('1, '0, res);
    send_block('0, '1, res);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, res);
    wait_quiet();
    write_reg(RegDecrypt, 64'd1);
    send_block('0, '0, res);
    send_block('1, '1, res);
    wait_quiet();
  endtask

  // Single key word rewrite, mode write with junk high bits, unused indexes
  task automatic test_register_writes();
    block_t res;
    write_reg(RegKeyFirst + 3'd2, 64'h0123456789abcdef);
    send_block(64'h8000000000000001, 64'h0000000000000001, res);
    wait_quiet();
    write_reg(RegDecrypt, 64'hfffffffffffffffe);
    send_block(64'h8000000000000001, 64'h0000000000000001, res);
    wait_quiet();
    for (int i = RegUnusedFirst; i < (1 << CfgIdxW); i++) begin
      write_reg(i[CfgIdxW-1:0], '1);
    end
    send_block(64'hfedcba9876543210, 64'h0f1e2d3c4b5a6978, res);
    wait_quiet();
  endtask

  // Each phase: fresh key and mode, random blocks, then the predicted outputs
  // sent back through the opposite direction
  task automatic test_random_traffic();
    block_t res;
    block_t outputs [$];
    for (int p = 0; p < 9; p++) begin
      burst_mode = (p == 4);
      case (p)
        0: load_key('1, '1, '1, '1);
        1: load_key('0, '0, '0, '0);
        default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      write_reg(RegDecrypt, {$urandom, $urandom_range(1)});
      outputs.delete();
      repeat (25) begin
        send_block(rand_word(), rand_word(), res);
        outputs = {outputs, res};
      end
      wait_quiet();
      write_reg(RegDecrypt, {$urandom, 31'd0, ~decrypt_sel});
      foreach (outputs[i]) send_block(outputs[i].upper, outputs[i].lower, res);
      wait_quiet();
    end
    burst_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: upper %h lower %h", out_if.result_upper,
                   out_if.result_lower);
      end else begin
        want = pending_blocks.pop_front();
        if (out_if.result_upper !== want.upper || out_if.result_lower !== want.lower) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: upper exp %h got %h, lower exp %h got %h",
                     want.upper, out_if.result_upper, want.lower, out_if.result_lower);
        end
      end
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.block_upper = '0;
    in_if.block_lower = '0;
    out_if.ready      = 1'b0;
    mismatches        = 0;
    cycles            = 0;
    burst_mode        = 1'b0;
    decrypt_sel       = 1'b0;
    round_keys_valid  = 1'b0;
    foreach (key_words[i]) key_words[i] = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_known_vector();
    test_field_extremes();
    test_register_writes();
    test_random_traffic();

    wait_quiet();
    mismatches += pending_blocks.size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
